// ===== hdl/acpi_ec_host_interface_unit_defines.svh =====
// assertion macros for the embedded-controller host interface
`ifndef ACPI_EC_HOST_INTERFACE_UNIT_DEFINES_SVH
`define ACPI_EC_HOST_INTERFACE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property with reset gating
`define EC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds during reset
`define EC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EC_ASSERT(lbl, clk, rst_n, prop, msg)
`define EC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/ec_hif_pkg.sv =====
// types and constants of the embedded-controller host interface
package ec_hif_pkg;

    localparam int unsigned AddrW  = 8;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned RegCnt = 256;

    typedef enum logic [1:0] {
        ACC_STATUS_READ   = 2'd0,
        ACC_COMMAND_WRITE = 2'd1,
        ACC_DATA_READ     = 2'd2,
        ACC_DATA_WRITE    = 2'd3
    } t_acc;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RD_ADDR = 2'd1,
        PH_WR_ADDR = 2'd2,
        PH_WR_VAL  = 2'd3
    } t_phase;

    localparam logic [ByteW-1:0] CMD_READ      = 8'h80;
    localparam logic [ByteW-1:0] CMD_WRITE     = 8'h81;
    localparam logic [ByteW-1:0] CMD_BURST_ON  = 8'h82;
    localparam logic [ByteW-1:0] CMD_BURST_OFF = 8'h83;
    localparam logic [ByteW-1:0] CMD_QUERY     = 8'h84;

    localparam logic [ByteW-1:0] BURST_ACK = 8'h90;
    localparam logic [ByteW-1:0] ST_OBF    = 8'h01;
    localparam logic [ByteW-1:0] ST_BURST  = 8'h10;

endpackage

// ===== hdl/ec_hif_ram.sv =====
// generic single-port-write, registered-read ram
module ec_hif_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/acpi_ec_host_interface_unit.sv =====
// top level of the embedded-controller host interface, device side
//
// slave channel s_axis: one host port access per transaction; tuser holds the
// access kind (status read, command write, data read, data write), tdata the
// byte the host writes. master channel m_axis: one result per access; tdata
// holds the byte read back (zero on writes), tuser the protocol error flag.
// results appear in an output register in the cycle after acceptance; a new
// access is taken while that result still waits if m_axis_tready is high, so
// one access per cycle unless a fetch holds tready low. a data write that ends
// the read command's address phase fetches the register byte from the 256-byte
// ram, a registered read, so tready drops in the cycle after that access.
// the register space reads as zero after reset through one valid bit per
// entry, cleared at once by reset; no clearing pass is needed.
// reset (synchronous, active low) clears phase, flags, buffer and valid bits.
// when m_axis_tready stays low the result is held and s_axis_tready falls
// until the result is taken.
`include "acpi_ec_host_interface_unit_defines.svh"

module acpi_ec_host_interface_unit
    import ec_hif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] write_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] access_kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] read_byte
    output logic       m_axis_tuser    // [0] protocol_error
);

    t_phase r_phase, n_phase;
    logic [ByteW-1:0] r_obuf;
    logic             r_obf;
    logic             r_burst;
    logic [AddrW-1:0] r_addr;
    logic [RegCnt-1:0] r_vld;
    logic             r_ld_pend;
    logic             r_ld_vld;
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_data;
    logic             r_out_err;

    logic             w_accept;
    t_acc             w_acc;
    logic [ByteW-1:0] w_rd;
    logic             w_err;
    logic             w_ram_we;
    logic             w_ram_re;
    logic             w_offer;
    logic [ByteW-1:0] w_offer_byte;
    logic             w_burst_set;
    logic             w_burst_clr;
    logic             w_obf_clr;
    logic             w_latch;
    logic [ByteW-1:0] w_ram_rdata;

    assign w_acc         = t_acc'(s_axis_tuser);
    assign s_axis_tready = !r_ld_pend && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ec_hif_ram #(
        .WIDTH (ByteW),
        .DEPTH (RegCnt)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (s_axis_tdata),
        .i_re    (w_ram_re),
        .i_raddr (s_axis_tdata),
        .o_rdata (w_ram_rdata)
    );

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            case (w_acc)
                ACC_COMMAND_WRITE: begin
                    case (s_axis_tdata)
                        CMD_READ:  n_phase = PH_RD_ADDR;
                        CMD_WRITE: n_phase = PH_WR_ADDR;
                        default:   n_phase = PH_IDLE;
                    endcase
                end
                ACC_DATA_WRITE: begin
                    case (r_phase)
                        PH_WR_ADDR: n_phase = PH_WR_VAL;
                        default:    n_phase = PH_IDLE;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // per-access actions and result
    always_comb begin
        w_rd         = '0;
        w_err        = 1'b0;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        w_offer      = 1'b0;
        w_offer_byte = '0;
        w_burst_set  = 1'b0;
        w_burst_clr  = 1'b0;
        w_obf_clr    = 1'b0;
        w_latch      = 1'b0;
        if (w_accept) begin
            case (w_acc)
                ACC_STATUS_READ: begin
                    w_rd = (r_obf ? ST_OBF : '0) | (r_burst ? ST_BURST : '0);
                end
                ACC_COMMAND_WRITE: begin
                    case (s_axis_tdata)
                        CMD_READ, CMD_WRITE, CMD_BURST_OFF: begin
                            w_burst_clr = (s_axis_tdata == CMD_BURST_OFF);
                        end
                        CMD_BURST_ON: begin
                            w_burst_set  = 1'b1;
                            w_offer      = 1'b1;
                            w_offer_byte = BURST_ACK;
                        end
                        CMD_QUERY: begin
                            w_offer      = 1'b1;
                            w_offer_byte = '0;
                        end
                        default: w_err = 1'b1;
                    endcase
                end
                ACC_DATA_READ: begin
                    w_rd      = r_obuf;
                    w_obf_clr = 1'b1;
                end
                default: begin
                    case (r_phase)
                        PH_RD_ADDR: begin
                            w_latch  = 1'b1;
                            w_ram_re = 1'b1;
                        end
                        PH_WR_ADDR: w_latch  = 1'b1;
                        PH_WR_VAL:  w_ram_we = 1'b1;
                        default:    w_err    = 1'b1;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_obuf      <= '0;
            r_obf       <= 1'b0;
            r_burst     <= 1'b0;
            r_addr      <= '0;
            r_vld       <= '0;
            r_ld_pend   <= 1'b0;
            r_ld_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ld_pend <= w_ram_re;
            if (w_ram_re) begin
                r_ld_vld <= r_vld[s_axis_tdata];
                r_obf    <= 1'b1;
            end else if (w_offer) begin
                r_obf <= 1'b1;
            end else if (w_obf_clr) begin
                r_obf <= 1'b0;
            end
            // fetched register byte lands in the output buffer
            if (r_ld_pend) begin
                r_obuf <= r_ld_vld ? w_ram_rdata : '0;
            end else if (w_offer) begin
                r_obuf <= w_offer_byte;
            end
            if (w_burst_set) begin
                r_burst <= 1'b1;
            end else if (w_burst_clr) begin
                r_burst <= 1'b0;
            end
            if (w_latch) begin
                r_addr <= s_axis_tdata;
            end
            if (w_ram_we) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_rd;
            r_out_err  <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

    `EC_ASSERT(a_no_accept_in_load, i_clk, i_rst_n, r_ld_pend |-> !w_accept, "access taken during register fetch")
    `EC_ASSERT(a_load_one_cycle, i_clk, i_rst_n, r_ld_pend |=> !r_ld_pend, "register fetch longer than one cycle")
    `EC_ASSERT(a_ram_write_phase, i_clk, i_rst_n, w_ram_we |-> (r_phase == PH_WR_VAL), "register write outside value phase")
    `EC_ASSERT(a_fetch_sets_obf, i_clk, i_rst_n, w_ram_re |=> (r_obf && r_ld_pend), "register fetch did not fill output buffer")

endmodule

// ===== sim/tb_acpi_ec_host_interface_unit.sv =====
// self-checking testbench of the embedded-controller host interface
`timescale 1ns / 1ps

module tb_acpi_ec_host_interface_unit;
    import ec_hif_pkg::*;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       protocol_error;
    } t_ec_reply;

    // tracks the host-visible state of the controller and the replies still owed
    class ec_host_tracker;
        logic [7:0]  reg_space [RegCnt];
        logic [7:0]  out_buf;
        bit          out_full;
        bit          burst_on;
        t_phase      phase;
        logic [7:0]  addr_latch;
        t_ec_reply   replies_due [$];
        int unsigned mismatches;

        function new();
            foreach (reg_space[i]) reg_space[i] = '0;
            out_buf    = '0;
            out_full   = 1'b0;
            burst_on   = 1'b0;
            phase      = PH_IDLE;
            addr_latch = '0;
            mismatches = 0;
        endfunction

        function void offer(logic [7:0] b);
            out_buf  = b;
            out_full = 1'b1;
        endfunction

        function void note_access(t_acc acc, logic [7:0] wb);
            t_ec_reply r;
            r = '0;
            case (acc)
                ACC_STATUS_READ: begin
                    r.read_byte = (out_full ? ST_OBF : 8'h00) | (burst_on ? ST_BURST : 8'h00);
                end
                ACC_COMMAND_WRITE: begin
                    // any command abandons a pending transaction
                    phase = PH_IDLE;
                    case (wb)
                        CMD_READ:      phase = PH_RD_ADDR;
                        CMD_WRITE:     phase = PH_WR_ADDR;
                        CMD_BURST_ON: begin
                            burst_on = 1'b1;
                            offer(BURST_ACK);
                        end
                        CMD_BURST_OFF: burst_on = 1'b0;
                        CMD_QUERY:     offer(8'h00);
                        default:       r.protocol_error = 1'b1;
                    endcase
                end
                ACC_DATA_READ: begin
                    r.read_byte = out_buf;
                    out_full    = 1'b0;
                end
                default: begin
                    case (phase)
                        PH_RD_ADDR: begin
                            addr_latch = wb;
                            offer(reg_space[wb]);
                            phase = PH_IDLE;
                        end
                        PH_WR_ADDR: begin
                            addr_latch = wb;
                            phase      = PH_WR_VAL;
                        end
                        PH_WR_VAL: begin
                            reg_space[addr_latch] = wb;
                            phase = PH_IDLE;
                        end
                        default: r.protocol_error = 1'b1;
                    endcase
                end
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [7:0] rd, logic err);
            t_ec_reply e;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: read_byte %h protocol_error %b", rd, err);
                return;
            end
            e = replies_due.pop_front();
            if (rd !== e.read_byte || err !== e.protocol_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: read_byte exp %h got %h, protocol_error exp %b got %b",
                             e.read_byte, rd, e.protocol_error, err);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;

    ec_host_tracker tracker;
    bit             gaps_on;
    int unsigned    access_count;

    acpi_ec_host_interface_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb_acpi_ec_host_interface_unit: FAIL");
        $finish;
    end

    // reply check comes before noting the new access: replies lag their accesses
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_reply(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_access(t_acc'(s_axis_tuser), s_axis_tdata);
        end
    end

    // result side back-pressure in random bursts
    initial begin
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left    = $urandom_range(1, 6) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_access(t_acc acc, logic [7:0] wb);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom);
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = acc;
        s_axis_tdata  = wb;
        do @(posedge i_clk); while (!s_axis_tready);
        access_count++;
        @(negedge i_clk);
    endtask

    task automatic send_read(t_acc acc);
        send_access(acc, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_addr();
        logic [7:0] pool [8] = '{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'hAA, 8'hFE, 8'hFF};
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    task automatic run_random_sequence();
        int unsigned kind;
        int unsigned n;
        logic [7:0]  cmds [5] = '{CMD_READ, CMD_WRITE, CMD_BURST_ON, CMD_BURST_OFF, CMD_QUERY};
        kind = $urandom_range(0, 12);
        if (kind <= 3) begin
            send_access(ACC_COMMAND_WRITE, CMD_WRITE);
            if ($urandom_range(0, 3) == 0) send_read(ACC_STATUS_READ);
            send_access(ACC_DATA_WRITE, pick_addr());
            send_access(ACC_DATA_WRITE, 8'($urandom));
        end else if (kind <= 7) begin
            send_access(ACC_COMMAND_WRITE, CMD_READ);
            send_access(ACC_DATA_WRITE, pick_addr());
            if ($urandom_range(0, 1) == 0) send_read(ACC_STATUS_READ);
            send_read(ACC_DATA_READ);
        end else if (kind == 8) begin
            send_access(ACC_COMMAND_WRITE, CMD_BURST_ON);
            if ($urandom_range(0, 1) == 0) send_read(ACC_DATA_READ);
        end else if (kind == 9) begin
            send_access(ACC_COMMAND_WRITE, CMD_BURST_OFF);
            send_read(ACC_STATUS_READ);
        end else if (kind == 10) begin
            send_access(ACC_COMMAND_WRITE, CMD_QUERY);
            send_read(ACC_DATA_READ);
        end else if (kind == 11) begin
            // transaction broken off by another command
            send_access(ACC_COMMAND_WRITE, $urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
            if ($urandom_range(0, 1) == 0) send_access(ACC_DATA_WRITE, pick_addr());
            if ($urandom_range(0, 1) == 0)
                send_access(ACC_COMMAND_WRITE, cmds[$urandom_range(0, 4)]);
            else
                send_access(ACC_COMMAND_WRITE, 8'($urandom));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    send_access(ACC_COMMAND_WRITE, 8'($urandom_range(8'h7E, 8'h86)));
                else
                    send_access(t_acc'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned waited;
        tracker       = new();
        gaps_on       = 1'b1;
        access_count  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACC_STATUS_READ;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // status and empty buffer right after reset, then stray data write
        send_access(ACC_STATUS_READ, 8'hFF);
        send_access(ACC_DATA_READ, 8'h00);
        send_access(ACC_DATA_WRITE, 8'hFF);
        send_access(ACC_COMMAND_WRITE, 8'h00);
        send_access(ACC_COMMAND_WRITE, 8'hFF);
        send_access(ACC_COMMAND_WRITE, CMD_WRITE);
        send_access(ACC_DATA_WRITE, 8'hFF);
        send_access(ACC_DATA_WRITE, 8'hA5);
        send_access(ACC_COMMAND_WRITE, CMD_READ);
        send_access(ACC_DATA_WRITE, 8'hFF);
        send_access(ACC_STATUS_READ, 8'h00);
        send_access(ACC_DATA_READ, 8'hFF);
        // buffer now empty: stale byte comes back
        send_access(ACC_DATA_READ, 8'h00);
        // command abandons the read in progress
        send_access(ACC_COMMAND_WRITE, CMD_READ);
        send_access(ACC_COMMAND_WRITE, CMD_WRITE);
        send_access(ACC_DATA_WRITE, 8'h00);
        send_access(ACC_DATA_WRITE, 8'h5A);
        // query overwrites the burst acknowledge while the buffer is full
        send_access(ACC_COMMAND_WRITE, CMD_BURST_ON);
        send_access(ACC_COMMAND_WRITE, CMD_QUERY);
        send_access(ACC_STATUS_READ, 8'hFF);
        send_access(ACC_DATA_READ, 8'h00);
        send_access(ACC_COMMAND_WRITE, CMD_BURST_OFF);
        send_access(ACC_COMMAND_WRITE, CMD_READ);
        send_access(ACC_DATA_WRITE, 8'h00);
        send_access(ACC_DATA_READ, 8'hFF);
        send_access(ACC_COMMAND_WRITE, 8'h7F);

        while (access_count < 650) begin
            gaps_on = (access_count < 550);
            run_random_sequence();
        end
        s_axis_tvalid = 1'b0;
        gaps_on       = 1'b0;

        waited = 0;
        while (tracker.replies_due.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (tracker.replies_due.size() != 0) begin
            $display("%0d replies never arrived", tracker.replies_due.size());
            tracker.mismatches += tracker.replies_due.size();
        end
        if (tracker.mismatches == 0)
            $display("tb_acpi_ec_host_interface_unit: PASS");
        else
            $display("tb_acpi_ec_host_interface_unit: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ec_hif_pkg.sv
hdl/ec_hif_ram.sv
hdl/acpi_ec_host_interface_unit.sv
sim/tb_acpi_ec_host_interface_unit.sv
